// ===== src/gmb_pkg.sv =====
// ----------------------------------------------------------------------------
// gmb_pkg
// Types and constants shared by the grid mass binning block.
// ----------------------------------------------------------------------------
package gmb_pkg;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_ADD_FOOD = 3'd1;
  localparam logic [2:0] OP_ADD_ENEMY = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_CELL_W = 3'd2;
  localparam logic [2:0] CFG_CELL_H = 3'd3;
  localparam logic [2:0] CFG_COLS = 3'd4;
  localparam logic [2:0] CFG_ROWS = 3'd5;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [23:0]        mass;
    logic [14:0]        radius;
  } gmb_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] best_x;
    logic signed [15:0] best_y;
    logic [31:0]        food_sum;
    logic [31:0]        enemy_sum;
  } gmb_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_BIN,
    ST_RD,
    ST_RMW,
    ST_QSETUP,
    ST_QROW,
    ST_QCELL,
    ST_QDIST,
    ST_QCMP,
    ST_DONE
  } gmb_state_e;

  typedef enum logic [1:0] {
    DV_CX,
    DV_CY,
    DV_RX,
    DV_RY
  } gmb_div_sel_e;

endpackage

// ===== src/gmb_div.sv =====
// ----------------------------------------------------------------------------
// gmb_div
// Restoring divider, one quotient bit per cycle, 18-bit dividend by 12 bits.
// ----------------------------------------------------------------------------
module gmb_div import gmb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [17:0] dividend_i,
  input  logic [11:0] divisor_i,
  output logic        done_o,
  output logic [17:0] quot_o
);

  logic [17:0] q_q, q_d;
  logic [12:0] r_q, r_d;
  logic [11:0] dv_q, dv_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [12:0] sh;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    dv_d = dv_q;
    cnt_d = cnt_q;
    run_d = run_q;
    sh = {r_q[11:0], q_q[17]};
    if (start_i) begin
      q_d = dividend_i;
      r_d = '0;
      dv_d = divisor_i;
      cnt_d = 5'd18;
      run_d = 1'b1;
    end else if (run_q) begin
      if (sh >= {1'b0, dv_q}) begin
        r_d = sh - {1'b0, dv_q};
        q_d = {q_q[16:0], 1'b1};
      end else begin
        r_d = sh;
        q_d = {q_q[16:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    dv_q <= dv_d;
  end

  assign done_o = run_q && (cnt_q == 5'd1);
  assign quot_o = {q_q[16:0], (sh >= {1'b0, dv_q})};

endmodule

// ===== src/gmb_store.sv =====
// ----------------------------------------------------------------------------
// gmb_store
// Food and enemy cell memories with one shared read and one write port.
// ----------------------------------------------------------------------------
module gmb_store import gmb_pkg::*; #(
  parameter int unsigned Cells = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic             we_food_i,
  input  logic             we_enemy_i,
  input  logic [31:0]      wdata_food_i,
  input  logic [31:0]      wdata_enemy_i,
  output logic [31:0]      food_o,
  output logic [31:0]      enemy_o
);

  logic [31:0] food_mem [Cells];
  logic [31:0] enemy_mem [Cells];

  always_ff @(posedge clk_i) begin
    if (we_food_i) begin
      food_mem[addr_i] <= wdata_food_i;
    end
    if (we_enemy_i) begin
      enemy_mem[addr_i] <= wdata_enemy_i;
    end
    food_o <= food_mem[addr_i];
    enemy_o <= enemy_mem[addr_i];
  end

endmodule

// ===== src/grid_mass_binning_with_radius_max.sv =====
// ----------------------------------------------------------------------------
// grid_mass_binning_with_radius_max
// Uniform grid of food and enemy mass sums with add, read, clear and query.
// ----------------------------------------------------------------------------
// One command at a time; busy is high from the accepting edge until the cycle
// of its single result strobe. Each divider pass is a load followed by 18
// quotient steps. An add or read inside the grid runs two divider passes, a
// memory read, a write or capture, and an output state; outside the grid it
// skips the memory read and the write or capture. A query runs four divider
// passes, a setup state, and then per row a row state and per cell in its
// window a center state, the squares of dx and dy in turn in the one
// multiplier and a compare state, and finally an output state. Clear sweeps
// all MAX_COLUMNS*MAX_ROWS cells one per cycle, then gives its output. After
// reset the same sweep runs over all cells with busy high and no strobe. The
// result is on result_o in the cycle that busy falls, with done_o high, and
// cannot be held off. Configuration is taken only while idle and start is
// low.
module grid_mass_binning_with_radius_max import gmb_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 16,
  parameter int unsigned MAX_ROWS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  gmb_in_t     cmd_i,
  output logic        done_o,
  output gmb_out_t    result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned Cells = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AddrW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam logic [CW-1:0] MaxC = CW'(MAX_COLUMNS);
  localparam logic [RW-1:0] MaxR = RW'(MAX_ROWS);

  logic signed [15:0] org_x_q, org_y_q;
  logic [11:0] cw_q, ch_q;
  logic [4:0]  cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      cw_q <= 12'd256;
      ch_q <= 12'd256;
      cols_q <= 5'd16;
      rows_q <= 5'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X: org_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: org_y_q <= cfg_data_i;
        CFG_CELL_W:   cw_q <= cfg_data_i[11:0];
        CFG_CELL_H:   ch_q <= cfg_data_i[11:0];
        CFG_COLS:     cols_q <= cfg_data_i[4:0];
        CFG_ROWS:     rows_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [11:0] w, h;
  logic [CW-1:0] ncol;
  logic [RW-1:0] nrow;
  logic [5:0] cols6, rows6;
  assign w = (cw_q == '0) ? 12'd1 : cw_q;
  assign h = (ch_q == '0) ? 12'd1 : ch_q;
  assign cols6 = (cols_q == '0) ? 6'd1 : {1'b0, cols_q};
  assign rows6 = (rows_q == '0) ? 6'd1 : {1'b0, rows_q};
  assign ncol = (32'(cols6) > MAX_COLUMNS) ? MaxC : CW'(cols6);
  assign nrow = (32'(rows6) > MAX_ROWS) ? MaxR : RW'(rows6);

  gmb_state_e st_q, st_d;
  gmb_in_t cmd_q;
  gmb_div_sel_e dsel_q, dsel_d;
  logic [AddrW:0] clr_q, clr_d;
  logic        init_q, init_d;
  logic [CW-1:0] c0_q, c0_d, c1_q, c1_d, c_q, c_d;
  logic [RW-1:0] r0_q, r0_d, r1_q, r1_d, r_q, r_d;
  logic found_q, found_d;
  logic [31:0] best_q, best_d;
  logic signed [31:0] bx_q, bx_d, by_q, by_d;
  logic signed [31:0] cx_q, cx_d, cy_q, cy_d;
  logic [63:0] acc_q, acc_d;
  logic        dist_ph_q, dist_ph_d;
  logic        out_v_q, out_v_d;
  gmb_out_t    out_q, out_d;

  assign cfg_ready_o = (st_q == ST_IDLE) && !start;

  // divider operand: offset p - org, signed 18 bits
  logic signed [17:0] p_off;
  logic               p_neg;
  logic [17:0]        div_a;
  logic [11:0]        div_b;
  logic               div_start;
  logic               div_done;
  logic [17:0]        div_q;
  logic signed [17:0] pv, ov;
  logic signed [17:0] rad_s;

  always_comb begin
    rad_s = (cmd_q.op == OP_QUERY) ? 18'($signed({1'b0, cmd_q.radius})) : 18'sd0;
    unique case (dsel_q)
      DV_CX: begin pv = 18'(cmd_q.pos_x) - rad_s;
        ov = 18'(org_x_q); end
      DV_CY: begin pv = 18'(cmd_q.pos_y) - rad_s;
        ov = 18'(org_y_q); end
      DV_RX: begin pv = 18'(cmd_q.pos_x) + rad_s;
        ov = 18'(org_x_q); end
      DV_RY: begin pv = 18'(cmd_q.pos_y) + rad_s;
        ov = 18'(org_y_q); end
      default: begin pv = '0; ov = '0; end
    endcase
    p_off = pv - ov;
    p_neg = p_off[17];
    div_a = p_neg ? 18'd0 : p_off;
    div_b = (dsel_q == DV_CX || dsel_q == DV_RX) ? w : h;
  end

  gmb_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .dividend_i(div_a),
    .divisor_i(div_b),
    .done_o(div_done),
    .quot_o(div_q)
  );

  logic neg_q, neg_d;
  logic [CW-1:0] qc;
  logic [RW-1:0] qr;
  assign qc = neg_q ? '0 : ((div_q >= 18'(ncol)) ? ncol - CW'(1) : CW'(div_q));
  assign qr = neg_q ? '0 : ((div_q >= 18'(nrow)) ? nrow - RW'(1) : RW'(div_q));

  // bounds
  logic in_b;
  logic signed [31:0] ext_x, ext_y, dxo, dyo;
  always_comb begin
    ext_x = 32'($signed({1'b0, ncol})) * 32'($signed({1'b0, w}));
    ext_y = 32'($signed({1'b0, nrow})) * 32'($signed({1'b0, h}));
    dxo = 32'(cmd_q.pos_x) - 32'(org_x_q);
    dyo = 32'(cmd_q.pos_y) - 32'(org_y_q);
    in_b = (dxo >= 0) && (dxo < ext_x) && (dyo >= 0) && (dyo < ext_y);
  end

  // memory
  logic [AddrW-1:0] addr;
  logic we_f, we_e;
  logic [31:0] wd_f, wd_e, rd_f, rd_e;
  logic [32:0] sum;

  gmb_store #(.Cells(Cells), .AddrW(AddrW)) u_store (
    .clk_i,
    .addr_i(addr),
    .we_food_i(we_f),
    .we_enemy_i(we_e),
    .wdata_food_i(wd_f),
    .wdata_enemy_i(wd_e),
    .food_o(rd_f),
    .enemy_o(rd_e)
  );

  // shared multiplier: squares of dx and dy
  logic signed [31:0] mul_a;
  logic signed [63:0] mul_p;
  assign mul_p = mul_a * mul_a;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7fff;
    else if (v < -32'sd32768) r = -16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  logic [AddrW-1:0] cell_addr;
  assign cell_addr = AddrW'(32'(r_q) * MAX_COLUMNS + 32'(c_q));

  always_comb begin
    st_d = st_q;
    dsel_d = dsel_q;
    clr_d = clr_q;
    init_d = init_q;
    c0_d = c0_q; c1_d = c1_q; c_d = c_q;
    r0_d = r0_q; r1_d = r1_q; r_d = r_q;
    found_d = found_q; best_d = best_q;
    bx_d = bx_q; by_d = by_q; cx_d = cx_q; cy_d = cy_q;
    acc_d = acc_q;
    dist_ph_d = dist_ph_q;
    neg_d = neg_q;
    out_v_d = 1'b0;
    out_d = out_q;
    div_start = 1'b0;
    addr = cell_addr;
    we_f = 1'b0; we_e = 1'b0;
    wd_f = '0; wd_e = '0;
    sum = '0;
    mul_a = dist_ph_q ? (cy_q - 32'(cmd_q.pos_y)) : (cx_q - 32'(cmd_q.pos_x));
    unique case (st_q)
      ST_IDLE: begin
        if (start) begin
          out_d = '0;
          unique case (cmd_i.op)
            OP_CLEAR: begin clr_d = '0; st_d = ST_CLEAR; end
            OP_ADD_FOOD, OP_ADD_ENEMY, OP_READ: begin
              dsel_d = DV_RX; st_d = ST_DIV; div_start = 1'b0;
            end
            OP_QUERY: begin dsel_d = DV_CX; st_d = ST_DIV; end
            default: st_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        addr = clr_q[AddrW-1:0];
        we_f = 1'b1; we_e = 1'b1;
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == Cells - 1) begin
          st_d = init_q ? ST_IDLE : ST_DONE;
          init_d = 1'b0;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        neg_d = p_neg;
        st_d = ST_BIN;
      end
      ST_BIN: begin
        if (div_done) begin
          if (cmd_q.op == OP_QUERY) begin
            unique case (dsel_q)
              DV_CX: begin c0_d = qc; dsel_d = DV_RX; st_d = ST_DIV; end
              DV_RX: begin c1_d = qc; dsel_d = DV_CY; st_d = ST_DIV; end
              DV_CY: begin r0_d = qr; dsel_d = DV_RY; st_d = ST_DIV; end
              default: begin r1_d = qr; st_d = ST_QSETUP; end
            endcase
          end else begin
            if (dsel_q == DV_RX) begin
              c_d = qc; dsel_d = DV_RY; st_d = ST_DIV;
            end else begin
              r_d = qr;
              st_d = in_b ? ST_RD : ST_DONE;
            end
          end
        end
      end
      ST_RD: st_d = ST_RMW;
      ST_RMW: begin
        out_d.hit = 1'b1;
        if (cmd_q.op == OP_ADD_FOOD) begin
          sum = {1'b0, rd_f} + {9'd0, cmd_q.mass};
          we_f = 1'b1; wd_f = sum[32] ? 32'hffff_ffff : sum[31:0];
        end else if (cmd_q.op == OP_ADD_ENEMY) begin
          sum = {1'b0, rd_e} + {9'd0, cmd_q.mass};
          we_e = 1'b1; wd_e = sum[32] ? 32'hffff_ffff : sum[31:0];
        end else begin
          out_d.food_sum = rd_f; out_d.enemy_sum = rd_e;
        end
        st_d = ST_DONE;
      end
      ST_QSETUP: begin
        found_d = 1'b0; best_d = '0;
        bx_d = 32'(cmd_q.pos_x); by_d = 32'(cmd_q.pos_y);
        r_d = r0_q;
        st_d = ST_QROW;
      end
      ST_QROW: begin
        c_d = c0_q;
        cy_d = 32'(org_y_q) + 32'(r_q) * 32'(h) + 32'(h[11:1]);
        st_d = ST_QCELL;
      end
      ST_QCELL: begin
        cx_d = 32'(org_x_q) + 32'(c_q) * 32'(w) + 32'(w[11:1]);
        dist_ph_d = 1'b0;
        acc_d = '0;
        st_d = ST_QDIST;
      end
      ST_QDIST: begin
        acc_d = acc_q + 64'(mul_p);
        dist_ph_d = !dist_ph_q;
        if (dist_ph_q) st_d = ST_QCMP;
      end
      ST_QCMP: begin
        if (acc_q <= 64'(30'(cmd_q.radius) * 30'(cmd_q.radius))) begin
          if (!found_q || rd_f > best_q) begin
            found_d = 1'b1; best_d = rd_f; bx_d = cx_q; by_d = cy_q;
          end
        end
        if (c_q == c1_q) begin
          if (r_q == r1_q) begin
            st_d = ST_DONE;
            out_d.hit = found_d;
            out_d.best_x = sat16(bx_d);
            out_d.best_y = sat16(by_d);
            out_d.food_sum = found_d ? best_d : '0;
          end else begin
            r_d = r_q + 1'b1; st_d = ST_QROW;
          end
        end else begin
          c_d = c_q + 1'b1; st_d = ST_QCELL;
        end
      end
      ST_DONE: begin
        out_v_d = 1'b1;
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR;
      clr_q <= '0;
      init_q <= 1'b1;
      out_v_q <= 1'b0;
      dsel_q <= DV_CX;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      init_q <= init_d;
      out_v_q <= out_v_d;
      dsel_q <= dsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && start) cmd_q <= cmd_i;
    c0_q <= c0_d; c1_q <= c1_d; c_q <= c_d;
    r0_q <= r0_d; r1_q <= r1_d; r_q <= r_d;
    found_q <= found_d; best_q <= best_d;
    bx_q <= bx_d; by_q <= by_d; cx_q <= cx_d; cy_q <= cy_d;
    acc_q <= acc_d;
    dist_ph_q <= dist_ph_d;
    neg_q <= neg_d;
    out_q <= out_d;
  end

  assign busy = (st_q != ST_IDLE);
  assign done_o = out_v_q;
  assign result_o = out_q;

endmodule

// ===== tb/grid_mass_binning_with_radius_max_tb.sv =====
// ----------------------------------------------------------------------------
// grid_mass_binning_with_radius_max_tb
// Drives clear, add, query, read and bad opcodes through several grid settings
// and compares every result strobe against a cycle-free software grid model.
// ----------------------------------------------------------------------------
module grid_mass_binning_with_radius_max_tb;
  import gmb_pkg::*;

  localparam int NCOLS = 16;
  localparam int NROWS = 16;
  localparam int LIMIT = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  gmb_in_t     cmd_i = '0;
  logic        done_o;
  gmb_out_t    result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  longint      org_x, org_y;
  int          cw, ch, ncol, nrow;
  logic [31:0] food_mem [NCOLS*NROWS];
  logic [31:0] enemy_mem [NCOLS*NROWS];
  gmb_out_t    expected_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          gap_pct = 0;

  grid_mass_binning_with_radius_max uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .done_o(done_o), .result_o(result_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
  endtask

  always @(posedge clk_i) begin
    gmb_out_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, '0);
      end else begin
        want = expected_q.pop_front();
        if (result_o.hit !== want.hit)
          report("hit", 32'(result_o.hit), 32'(want.hit));
        if (result_o.best_x !== want.best_x)
          report("best_x", 32'(result_o.best_x), 32'(want.best_x));
        if (result_o.best_y !== want.best_y)
          report("best_y", 32'(result_o.best_y), 32'(want.best_y));
        if (result_o.food_sum !== want.food_sum)
          report("food_sum", result_o.food_sum, want.food_sum);
        if (result_o.enemy_sum !== want.enemy_sum)
          report("enemy_sum", result_o.enemy_sum, want.enemy_sum);
      end
    end
  end

  function automatic longint eff_size(int s);
    return (s == 0) ? 1 : s;
  endfunction

  function automatic longint eff_cnt(int c, int mx);
    if (c < 1) return 1;
    if (c > mx) return mx;
    return c;
  endfunction

  function automatic longint bin_of(longint p, longint org, longint sz, longint cnt);
    longint q;
    q = (p - org) / sz;
    if (q < 0) q = 0;
    if (q > cnt - 1) q = cnt - 1;
    return q;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [23:0] b);
    logic [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic gmb_out_t grid_predict(gmb_in_t c);
    gmb_out_t r;
    longint px, py, rad, w, h, cols, rows, c0, c1, r0, r1, cx, cy, dx, dy, bx, by;
    int idx;
    logic found;
    logic [31:0] best;
    r = '0;
    px = c.pos_x;
    py = c.pos_y;
    rad = c.radius;
    w = eff_size(cw);
    h = eff_size(ch);
    cols = eff_cnt(ncol, NCOLS);
    rows = eff_cnt(nrow, NROWS);
    case (c.op)
      OP_CLEAR: begin
        for (int i = 0; i < NCOLS*NROWS; i++) begin
          food_mem[i] = '0;
          enemy_mem[i] = '0;
        end
      end
      OP_ADD_FOOD, OP_ADD_ENEMY, OP_READ: begin
        if (px >= org_x && px < org_x + cols*w && py >= org_y && py < org_y + rows*h) begin
          idx = int'(bin_of(py, org_y, h, rows) * NCOLS + bin_of(px, org_x, w, cols));
          if (c.op == OP_ADD_FOOD) food_mem[idx] = sat_sum(food_mem[idx], c.mass);
          else if (c.op == OP_ADD_ENEMY) enemy_mem[idx] = sat_sum(enemy_mem[idx], c.mass);
          else begin
            r.food_sum = food_mem[idx];
            r.enemy_sum = enemy_mem[idx];
          end
          r.hit = 1'b1;
        end
      end
      OP_QUERY: begin
        c0 = bin_of(px - rad, org_x, w, cols);
        c1 = bin_of(px + rad, org_x, w, cols);
        r0 = bin_of(py - rad, org_y, h, rows);
        r1 = bin_of(py + rad, org_y, h, rows);
        found = 1'b0;
        best = '0;
        bx = px;
        by = py;
        for (longint rr = r0; rr <= r1; rr++) begin
          for (longint cc = c0; cc <= c1; cc++) begin
            cx = org_x + cc*w + w/2;
            cy = org_y + rr*h + h/2;
            dx = cx - px;
            dy = cy - py;
            if (dx*dx + dy*dy <= rad*rad) begin
              idx = int'(rr*NCOLS + cc);
              if (!found || food_mem[idx] > best) begin
                found = 1'b1;
                best = food_mem[idx];
                bx = cx;
                by = cy;
              end
            end
          end
        end
        r.hit = found;
        r.best_x = clamp16(bx);
        r.best_y = clamp16(by);
        r.food_sum = found ? best : '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_cmd(input gmb_in_t c);
    do @(negedge clk_i); while ($urandom_range(99) < gap_pct);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q = {expected_q, grid_predict(c)};
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_ORIGIN_X: org_x = $signed(val);
      CFG_ORIGIN_Y: org_y = $signed(val);
      CFG_CELL_W:   cw = int'(val[11:0]);
      CFG_CELL_H:   ch = int'(val[11:0]);
      CFG_COLS:     ncol = int'(val[4:0]);
      CFG_ROWS:     nrow = int'(val[4:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(input int ox, input int oy, input int w, input int h,
                          input int nc, input int nr);
    drain();
    write_reg(CFG_ORIGIN_X, ox[15:0]);
    write_reg(CFG_ORIGIN_Y, oy[15:0]);
    write_reg(CFG_CELL_W, w[15:0]);
    write_reg(CFG_CELL_H, h[15:0]);
    write_reg(CFG_COLS, nc[15:0]);
    write_reg(CFG_ROWS, nr[15:0]);
  endtask

  function automatic gmb_in_t make_cmd(logic [2:0] op, int x, int y, logic [23:0] m,
                                       logic [14:0] rad);
    gmb_in_t c;
    c.op = op;
    c.pos_x = x[15:0];
    c.pos_y = y[15:0];
    c.mass = m;
    c.radius = rad;
    return c;
  endfunction

  function automatic int grid_coord(longint org, int sz, int cnt);
    longint span, v;
    span = eff_size(sz) * eff_cnt(cnt, 16);
    v = org - 8 + $urandom_range(32'(span + 15));
    if ($urandom_range(9) == 0) v = $signed(16'($urandom));
    return int'($signed(clamp16(v)));
  endfunction

  function automatic gmb_in_t rand_cmd();
    logic [2:0] op;
    logic [23:0] m;
    logic [14:0] rad;
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) op = OP_ADD_FOOD;
    else if (sel < 60) op = OP_ADD_ENEMY;
    else if (sel < 78) op = OP_QUERY;
    else if (sel < 95) op = OP_READ;
    else if (sel < 97) op = OP_CLEAR;
    else op = 3'($urandom_range(5, 7));
    m = ($urandom_range(19) == 0) ? 24'($urandom) | 24'hF00000 : 24'($urandom_range(4095));
    rad = ($urandom_range(9) == 0) ? 15'($urandom)
                                   : 15'($urandom_range(32'(4 * eff_size(cw))));
    return make_cmd(op, grid_coord(org_x, cw, ncol), grid_coord(org_y, ch, nrow),
                    m, rad);
  endfunction

  task automatic test_directed();
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_ADD_FOOD, 0, 0, 24'hFFFFFF, 0));
    send_cmd(make_cmd(OP_ADD_FOOD, 100, 200, 24'h000100, 0));
    send_cmd(make_cmd(OP_ADD_ENEMY, 4095, 4095, 24'hFFFFFF, 0));
    send_cmd(make_cmd(OP_ADD_FOOD, 4096, 10, 24'h1, 0));
    send_cmd(make_cmd(OP_ADD_FOOD, -1, 10, 24'h1, 0));
    send_cmd(make_cmd(OP_READ, 4095, 4095, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_QUERY, 128, 128, 0, 0));
    send_cmd(make_cmd(OP_QUERY, 300, 300, 0, 400));
    send_cmd(make_cmd(OP_QUERY, -32768, -32768, 0, 15'h7FFF));
    send_cmd(make_cmd(OP_QUERY, 32767, 32767, 0, 15'h7FFF));
    send_cmd(make_cmd(OP_QUERY, 10, 10, 0, 1));
    send_cmd(make_cmd(3'd5, 1, 1, 24'h5, 5));
    send_cmd(make_cmd(3'd7, -1, -1, 24'hFFFFFF, 15'h7FFF));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 100, 200, 0, 0));
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 260; i++) begin
      send_cmd(make_cmd(OP_ADD_FOOD, 5, 5, 24'hFFFFFF, 0));
      if (i % 40 == 0) send_cmd(make_cmd(OP_READ, 5, 5, 0, 0));
    end
    send_cmd(make_cmd(OP_READ, 5, 5, 0, 0));
    send_cmd(make_cmd(OP_QUERY, 5, 5, 0, 300));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_cmd(rand_cmd());
  endtask

  task automatic test_settings();
    set_grid(-32768, -32768, 4095, 4095, 16, 16);
    gap_pct = 8;
    test_random(40);
    set_grid(32767, 32767, 1, 1, 1, 1);
    test_random(30);
    set_grid(-100, 50, 0, 0, 0, 0);
    test_random(30);
    set_grid(-300, -40, 37, 91, 31, 17);
    gap_pct = 47;
    test_random(60);
    drain();
    set_grid(1000, -2000, 3, 5, 7, 4);
    test_random(60);
    set_grid(0, 0, 256, 256, 16, 16);
    gap_pct = 0;
    test_random(44);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    org_x = 0;
    org_y = 0;
    cw = 256;
    ch = 256;
    ncol = 16;
    nrow = 16;
    for (int i = 0; i < NCOLS*NROWS; i++) begin
      food_mem[i] = '0;
      enemy_mem[i] = '0;
    end
    @(negedge clk_i);
    test_directed();
    test_saturation();
    test_settings();
    drain();
    repeat (300) @(negedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/gmb_pkg.sv
src/gmb_div.sv
src/gmb_store.sv
src/grid_mass_binning_with_radius_max.sv
tb/grid_mass_binning_with_radius_max_tb.sv
